>>> hw/rtl/dsm_pkg.sv
// ----------------------------------------------------------------------------
// dsm_pkg
// Shared types and constants of the data slot map.
// ----------------------------------------------------------------------------
package dsm_pkg;

	localparam int ADDR_BITS      = 48;
	localparam int OFFSET_BITS    = 24;
	localparam int MAP_DEPTH_DEF  = 256;
	localparam int SLOT_BYTES_DEF = 32;
	localparam int HOLE_BYTES     = 8;
	localparam int HOLE_SHIFT     = 3;

	localparam logic [1:0] ACT_NEAR  = 2'd0;
	localparam logic [1:0] ACT_ADD   = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;
	localparam logic [1:0] ACT_NOP   = 2'd3;

	localparam logic [1:0] KIND_EXACT = 2'd0;
	localparam logic [1:0] KIND_NEAR  = 2'd1;
	localparam logic [1:0] KIND_NEW   = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	typedef logic [ADDR_BITS-1:0] addr_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DISPATCH, ST_LOOP, ST_SRD, ST_SCMP, ST_CRD, ST_CCMP,
		ST_NCHK, ST_NCMP, ST_ALLOC, ST_SHRD, ST_SHWR, ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_CLEAR, OP_NONE_RES, OP_SRD, OP_SCMP, OP_CRD,
		OP_EXACT, OP_NRD, OP_NEAR, OP_FULL, OP_ALLOC, OP_SHRD, OP_SHWR,
		OP_INSERT, OP_EMIT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       lo_lt_hi;
		logic       lo_lt_count;
		logic       key_eq;
		logic       lo_nz;
		logic       near_ok;
		logic       map_full;
		logic       sh_gt_lo;
		logic       out_free;
	} status_t;

endpackage

>>> hw/rtl/dsm_if.sv
// ----------------------------------------------------------------------------
// dsm_if
// Request, response and configuration channels of the data slot map.
// ----------------------------------------------------------------------------
interface dsm_req_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 action;
	logic [dsm_pkg::ADDR_BITS-1:0] key_address;
	modport source (output valid, action, key_address, input ready);
	modport sink (input valid, action, key_address, output ready);
endinterface

interface dsm_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [dsm_pkg::ADDR_BITS-1:0]   slot_address;
	logic [dsm_pkg::OFFSET_BITS-1:0] byte_offset;
	logic [1:0]                      match_kind;
	logic                            store_key;
	logic                            map_full;
	modport source (output valid, slot_address, byte_offset, match_kind, store_key,
		map_full, input ready);
	modport sink (input valid, slot_address, byte_offset, match_kind, store_key,
		map_full, output ready);
endinterface

interface dsm_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [dsm_pkg::ADDR_BITS-1:0] arena_base;
	modport source (output valid, arena_base, input ready);
	modport sink (input valid, arena_base, output ready);
endinterface

>>> hw/rtl/dsm_ctrl.sv
// ----------------------------------------------------------------------------
// dsm_ctrl
// Sequencer: search, exact and near checks, allocation, insertion shift.
// ----------------------------------------------------------------------------
module dsm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  dsm_pkg::status_t sts,
	output dsm_pkg::cmd_t    cmd
);
	import dsm_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				if (sts.action inside {ACT_CLEAR, ACT_NOP}) state_d = ST_DONE;
				else state_d = ST_LOOP;
			end
			ST_LOOP:     state_d = sts.lo_lt_hi ? ST_SRD : ST_CRD;
			ST_SRD:      state_d = ST_SCMP;
			ST_SCMP:     state_d = ST_LOOP;
			ST_CRD:      state_d = sts.lo_lt_count ? ST_CCMP : ST_NCHK;
			ST_CCMP:     state_d = sts.key_eq ? ST_DONE : ST_NCHK;
			ST_NCHK: begin
				state_d = (sts.action == ACT_NEAR && sts.lo_nz) ? ST_NCMP : ST_ALLOC;
			end
			ST_NCMP:     state_d = sts.near_ok ? ST_DONE : ST_ALLOC;
			ST_ALLOC:    state_d = sts.map_full ? ST_DONE : ST_SHRD;
			ST_SHRD:     state_d = sts.sh_gt_lo ? ST_SHWR : ST_DONE;
			ST_SHWR:     state_d = ST_SHRD;
			ST_DONE:     if (sts.out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = OP_NONE;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE:     if (in_valid) cmd.op = OP_LOAD;
			ST_DISPATCH: begin
				if (sts.action == ACT_CLEAR) cmd.op = OP_CLEAR;
				else if (sts.action == ACT_NOP) cmd.op = OP_NONE_RES;
			end
			ST_SRD:      cmd.op = OP_SRD;
			ST_SCMP:     cmd.op = OP_SCMP;
			ST_CRD:      if (sts.lo_lt_count) cmd.op = OP_CRD;
			ST_CCMP:     if (sts.key_eq) cmd.op = OP_EXACT;
			ST_NCHK:     if (sts.action == ACT_NEAR && sts.lo_nz) cmd.op = OP_NRD;
			ST_NCMP:     if (sts.near_ok) cmd.op = OP_NEAR;
			ST_ALLOC:    cmd.op = sts.map_full ? OP_FULL : OP_ALLOC;
			ST_SHRD:     cmd.op = sts.sh_gt_lo ? OP_SHRD : OP_INSERT;
			ST_SHWR:     cmd.op = OP_SHWR;
			ST_DONE:     if (sts.out_free) cmd.op = OP_EMIT;
			default:     cmd.op = OP_NONE;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid) |=> state_q == ST_DISPATCH)
		else $error("accepted word not dispatched");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHWR) |=> state_q == ST_SHRD)
		else $error("shift write not followed by read");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !sts.out_free) |=> state_q == ST_DONE)
		else $error("result dropped while output busy");

endmodule

>>> hw/rtl/dsm_datapath.sv
// ----------------------------------------------------------------------------
// dsm_datapath
// Map memory, search bounds, slot allocator and result register.
// ----------------------------------------------------------------------------
module dsm_datapath #(
	parameter int MAP_DEPTH  = dsm_pkg::MAP_DEPTH_DEF,
	parameter int SLOT_BYTES = dsm_pkg::SLOT_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dsm_pkg::cmd_t                   cmd,
	output dsm_pkg::status_t                sts,
	input  logic [1:0]                      in_action,
	input  dsm_pkg::addr_t                  in_key,
	input  logic                            cfg_we,
	input  dsm_pkg::addr_t                  cfg_data,
	input  logic                            out_ready,
	output logic                            out_valid,
	output dsm_pkg::addr_t                  out_slot,
	output logic [dsm_pkg::OFFSET_BITS-1:0] out_offset,
	output logic [1:0]                      out_kind,
	output logic                            out_store,
	output logic                            out_full
);
	import dsm_pkg::*;

	localparam int AW    = $clog2(MAP_DEPTH);
	localparam int CW    = $clog2(MAP_DEPTH + 1);
	localparam int HOLES = SLOT_BYTES / HOLE_BYTES;
	localparam int HCW   = $clog2(HOLES + 1);
	localparam logic [CW-1:0]  DEPTH_C = CW'(MAP_DEPTH);
	localparam logic [HCW-1:0] HOLES_C = HCW'(HOLES);
	localparam addr_t          SLOT_C  = addr_t'(SLOT_BYTES);

	logic [2*ADDR_BITS-1:0] mem [MAP_DEPTH];

	logic [1:0]   action_q;
	addr_t        key_q, arena_q, next_slot_q, hole_q;
	logic [CW-1:0]  lo_q, hi_q, mid_q, count_q, sh_q;
	logic [HCW-1:0] hcnt_q;
	addr_t        rkey_q, rslot_q;

	addr_t        res_slot_q;
	logic [OFFSET_BITS-1:0] res_off_q;
	logic [1:0]   res_kind_q;
	logic         res_store_q, res_full_q;

	logic         out_valid_q;
	addr_t        out_slot_q;
	logic [OFFSET_BITS-1:0] out_off_q;
	logic [1:0]   out_kind_q;
	logic         out_store_q, out_full_q;

	logic [CW-1:0] mid;
	logic [CW-1:0] sh_m1, lo_m1;
	addr_t        delta, new_next;
	logic [HCW-1:0] hcnt_new;
	logic [AW-1:0] rd_addr;
	logic         rd_en;

	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign sh_m1    = sh_q - CW'(1);
	assign lo_m1    = lo_q - CW'(1);
	assign delta    = key_q - rkey_q;
	assign new_next = (hcnt_q == '0) ? (next_slot_q - SLOT_C) : next_slot_q;
	assign hcnt_new = ((hcnt_q == '0) ? HOLES_C : hcnt_q) - HCW'(1);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = mid[AW-1:0];
		case (cmd.op)
			OP_SRD:  begin rd_en = 1'b1; rd_addr = mid[AW-1:0]; end
			OP_CRD:  begin rd_en = 1'b1; rd_addr = lo_q[AW-1:0]; end
			OP_NRD:  begin rd_en = 1'b1; rd_addr = lo_m1[AW-1:0]; end
			OP_SHRD: begin rd_en = 1'b1; rd_addr = sh_m1[AW-1:0]; end
			default: rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			{rkey_q, rslot_q} <= mem[rd_addr];
		end
		if (cmd.op == OP_SHWR) begin
			mem[sh_q[AW-1:0]] <= {rkey_q, rslot_q};
		end else if (cmd.op == OP_INSERT) begin
			mem[lo_q[AW-1:0]] <= {key_q, hole_q};
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				action_q <= in_action;
				key_q    <= in_key;
				lo_q     <= '0;
				hi_q     <= count_q;
			end
			OP_SRD:  mid_q <= mid;
			OP_SCMP: begin
				if (rkey_q < key_q) lo_q <= mid_q + CW'(1);
				else hi_q <= mid_q;
			end
			OP_ALLOC: begin
				hole_q <= new_next + (addr_t'(hcnt_new) << HOLE_SHIFT);
				sh_q   <= count_q;
			end
			OP_SHWR: sh_q <= sh_m1;
			default: ;
		endcase
		case (cmd.op)
			OP_CLEAR, OP_NONE_RES, OP_FULL: begin
				res_slot_q  <= '0;
				res_off_q   <= '0;
				res_kind_q  <= KIND_NONE;
				res_store_q <= 1'b0;
				res_full_q  <= (cmd.op == OP_FULL);
			end
			OP_EXACT: begin
				res_slot_q  <= rslot_q;
				res_off_q   <= '0;
				res_kind_q  <= KIND_EXACT;
				res_store_q <= 1'b0;
				res_full_q  <= 1'b0;
			end
			OP_NEAR: begin
				res_slot_q  <= rslot_q + delta;
				res_off_q   <= delta[OFFSET_BITS-1:0];
				res_kind_q  <= KIND_NEAR;
				res_store_q <= 1'b0;
				res_full_q  <= 1'b0;
			end
			OP_INSERT: begin
				res_slot_q  <= hole_q;
				res_off_q   <= '0;
				res_kind_q  <= KIND_NEW;
				res_store_q <= 1'b1;
				res_full_q  <= 1'b0;
			end
			default: ;
		endcase
		if (cmd.op == OP_EMIT) begin
			out_slot_q  <= res_slot_q;
			out_off_q   <= res_off_q;
			out_kind_q  <= res_kind_q;
			out_store_q <= res_store_q;
			out_full_q  <= res_full_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_q     <= '0;
			next_slot_q <= '0;
			count_q     <= '0;
			hcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) arena_q <= cfg_data;
			case (cmd.op)
				OP_CLEAR: begin
					count_q     <= '0;
					hcnt_q      <= '0;
					next_slot_q <= arena_q;
				end
				OP_ALLOC: begin
					next_slot_q <= new_next;
					hcnt_q      <= hcnt_new;
				end
				OP_INSERT: count_q <= count_q + CW'(1);
				default: ;
			endcase
			if (cmd.op == OP_EMIT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.action      = action_q;
		sts.lo_lt_hi    = (lo_q < hi_q);
		sts.lo_lt_count = (lo_q < count_q);
		sts.key_eq      = (rkey_q == key_q);
		sts.lo_nz       = (lo_q != '0);
		sts.near_ok     = (delta[ADDR_BITS-1:OFFSET_BITS] == '0);
		sts.map_full    = (count_q >= DEPTH_C);
		sts.sh_gt_lo    = (sh_q > lo_q);
		sts.out_free    = !out_valid_q || out_ready;
	end

	assign out_valid  = out_valid_q;
	assign out_slot   = out_slot_q;
	assign out_offset = out_off_q;
	assign out_kind   = out_kind_q;
	assign out_store  = out_store_q;
	assign out_full   = out_full_q;

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= DEPTH_C)
		else $error("map count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n) hcnt_q <= HOLES_C)
		else $error("hole count beyond slot");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_INSERT) |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow map");

endmodule

>>> hw/rtl/data_slot_map_alloc_or_find.sv
// ----------------------------------------------------------------------------
// data_slot_map_alloc_or_find
// Sorted address-to-slot map with lower-bound search and slot allocation.
// ----------------------------------------------------------------------------
// Channels: req carries action and key_address; rsp returns one word per
// request (slot_address, byte_offset, match_kind, store_key, map_full); cfg
// writes arena_base, always ready, taken effect at the next clear action.
// One request is handled at a time; req is ready only while the sequencer
// is idle. The map is a single memory read one entry per cycle with a
// registered read, so the cost is set by its port:
//   clear / unused action: dispatch, then done
//   search: loop, read and compare per binary step, ceil(log2(count+1)) steps
//   exact/near checks: a read and a compare each, then allocation
//   insertion: a read and a write per entry above the insert point, then the insert
// The result sits in an output register, so a new request is taken while
// rsp is stalled; a second finished result waits in the sequencer until the
// register frees. Reset empties the map and hole stack and clears
// arena_base; map memory is not cleared.
// ----------------------------------------------------------------------------
module data_slot_map_alloc_or_find #(
	parameter int MAP_DEPTH  = dsm_pkg::MAP_DEPTH_DEF,
	parameter int SLOT_BYTES = dsm_pkg::SLOT_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	dsm_req_if.sink   req,
	dsm_rsp_if.source rsp,
	dsm_cfg_if.sink   cfg
);
	import dsm_pkg::*;

	cmd_t    cmd;
	status_t sts;

	assign cfg.ready = 1'b1;

	dsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dsm_datapath #(
		.MAP_DEPTH  (MAP_DEPTH),
		.SLOT_BYTES (SLOT_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_action  (req.action),
		.in_key     (req.key_address),
		.cfg_we     (cfg.valid),
		.cfg_data   (cfg.arena_base),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.out_slot   (rsp.slot_address),
		.out_offset (rsp.byte_offset),
		.out_kind   (rsp.match_kind),
		.out_store  (rsp.store_key),
		.out_full   (rsp.map_full)
	);

endmodule

>>> bench/data_slot_map_alloc_or_find_tb.sv
// ----------------------------------------------------------------------------
// data_slot_map_alloc_or_find_tb
// Self-checking bench for the data slot map. A directed table covers reset,
// extremes, clear and the unused action, then random traffic clustered around
// a few bases drives hits, near matches, allocation and a full map. Every
// response word is checked against an in-bench model of the sorted map.
// ----------------------------------------------------------------------------
module data_slot_map_alloc_or_find_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dsm_pkg::*;

	localparam int DEPTH      = MAP_DEPTH_DEF;
	localparam int HOLES      = SLOT_BYTES_DEF / HOLE_BYTES;
	localparam int NEAR_LIM   = 1 << OFFSET_BITS;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		addr_t       slot;
		logic [23:0] offs;
		logic [1:0]  kind;
		logic        store;
		logic        full;
	} word_t;

	typedef struct {
		logic [1:0] action;
		addr_t      key;
		bit         fixed;
		word_t      want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dsm_req_if req ();
	dsm_rsp_if rsp ();
	dsm_cfg_if cfg ();

	data_slot_map_alloc_or_find i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req.sink),
		.rsp   (rsp.source),
		.cfg   (cfg.sink)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model state
	addr_t keys_m[DEPTH];
	addr_t slots_m[DEPTH];
	int    count_m;
	addr_t holes_m[HOLES];
	int    holes_n;
	addr_t next_m;
	addr_t base_m;

	word_t pending_q[$];
	int    errors = 0;
	int    n_sent = 0;
	int    n_got = 0;
	int    n_full = 0;
	int    n_near = 0;
	int    idle_cycles = 0;
	bit    rsp_hold = 0;

	function automatic word_t map_lookup(logic [1:0] act, addr_t key);
		word_t r;
		int lo, hi, mid;
		addr_t delta, hole;
		r = '0;
		r.kind = KIND_NONE;
		if (act == ACT_CLEAR) begin
			count_m = 0;
			holes_n = 0;
			next_m = base_m;
			return r;
		end
		if (act == ACT_NOP)
			return r;
		lo = 0;
		hi = count_m;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (keys_m[mid] < key)
				lo = mid + 1;
			else
				hi = mid;
		end
		if (lo < count_m && keys_m[lo] == key) begin
			r.slot = slots_m[lo];
			r.kind = KIND_EXACT;
			return r;
		end
		if (act == ACT_NEAR && lo > 0) begin
			delta = key - keys_m[lo-1];
			if (delta < NEAR_LIM) begin
				r.slot = slots_m[lo-1] + delta;
				r.offs = delta[23:0];
				r.kind = KIND_NEAR;
				return r;
			end
		end
		if (count_m >= DEPTH) begin
			r.full = 1'b1;
			return r;
		end
		if (holes_n == 0) begin
			next_m = next_m - addr_t'(SLOT_BYTES_DEF);
			for (int i = 0; i < HOLES; i++)
				holes_m[i] = next_m + addr_t'(i * HOLE_BYTES);
			holes_n = HOLES;
		end
		holes_n--;
		hole = holes_m[holes_n];
		for (int i = count_m; i > lo; i--) begin
			keys_m[i] = keys_m[i-1];
			slots_m[i] = slots_m[i-1];
		end
		keys_m[lo] = key;
		slots_m[lo] = hole;
		count_m++;
		r.slot = hole;
		r.kind = KIND_NEW;
		r.store = 1'b1;
		return r;
	endfunction

	// valid stays high into the next word when no gap is drawn
	task automatic send_word(logic [1:0] act, addr_t key, bit fixed, word_t want);
		word_t p;
		int gap;
		gap = $urandom_range(0, 10);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.action <= act;
		req.key_address <= key;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		p = map_lookup(act, key);
		if (fixed && p != want) begin
			$error("table row disagrees with model: %h vs %h", want, p);
			errors++;
		end
		if (p.full) n_full++;
		if (p.kind == KIND_NEAR) n_near++;
		pending_q.push_back(p);
		n_sent++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_base(addr_t v);
		cfg.valid <= 1'b1;
		cfg.arena_base <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		base_m = v;
	endtask

	function automatic word_t w(addr_t s, logic [23:0] o, logic [1:0] k, logic st, logic f);
		word_t r;
		r.slot = s; r.offs = o; r.kind = k; r.store = st; r.full = f;
		return r;
	endfunction

	// response side
	initial begin
		int gap;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = rsp_hold ? 0 : $urandom_range(0, 10);
			if ($urandom_range(0, 3) == 0) gap = 0;
			if (gap > 0 || rsp_hold) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(posedge clk);
				while (rsp_hold) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		word_t got, exp_w;
		if (rsp.valid && rsp.ready) begin
			got = '{rsp.slot_address, rsp.byte_offset, rsp.match_kind, rsp.store_key,
				rsp.map_full};
			n_got++;
			if (pending_q.size() == 0) begin
				$error("unexpected response word %h", got);
				errors++;
			end else begin
				exp_w = pending_q.pop_front();
				if (got.slot !== exp_w.slot) begin
					$error("slot_address exp %h got %h", exp_w.slot, got.slot); errors++;
				end
				if (got.offs !== exp_w.offs) begin
					$error("byte_offset exp %h got %h", exp_w.offs, got.offs); errors++;
				end
				if (got.kind !== exp_w.kind) begin
					$error("match_kind exp %0d got %0d", exp_w.kind, got.kind); errors++;
				end
				if (got.store !== exp_w.store) begin
					$error("store_key exp %0d got %0d", exp_w.store, got.store); errors++;
				end
				if (got.full !== exp_w.full) begin
					$error("map_full exp %0d got %0d", exp_w.full, got.full); errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// long receiver stall while the map fill keeps sending
	initial begin
		@(posedge arst_n);
		wait (n_sent >= 100);
		@(posedge clk);
		rsp_hold = 1;
		repeat (400) @(posedge clk);
		rsp_hold = 0;
	end

	initial begin
		row_t  tbl[$];
		addr_t mx, b, k;
		int    r;
		mx = '1;
		req.valid = 1'b0;
		req.action = ACT_NOP;
		req.key_address = '0;
		cfg.valid = 1'b0;
		cfg.arena_base = '0;
		count_m = 0; holes_n = 0; next_m = '0; base_m = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// arena base 0 after reset: first slot wraps to the top of the space
		tbl.push_back('{ACT_NOP,   mx,  1, w('0, 0, KIND_NONE, 0, 0)});
		tbl.push_back('{ACT_ADD,   '0,  1, w(mx - 7, 0, KIND_NEW, 1, 0)});
		tbl.push_back('{ACT_ADD,   '0,  1, w(mx - 7, 0, KIND_EXACT, 0, 0)});
		tbl.push_back('{ACT_NEAR,  48'hff_ffff, 1, w(48'hff_fff7, 24'hff_ffff, KIND_NEAR, 0, 0)});
		tbl.push_back('{ACT_NEAR,  48'h100_0000, 1, w(mx - 15, 0, KIND_NEW, 1, 0)});
		tbl.push_back('{ACT_ADD,   mx,  0, '0});
		tbl.push_back('{ACT_NEAR,  mx - 1, 0, '0});
		tbl.push_back('{ACT_ADD,   48'h5555_5555_5555, 0, '0});
		tbl.push_back('{ACT_ADD,   48'haaaa_aaaa_aaaa, 0, '0});
		tbl.push_back('{ACT_NEAR,  48'h5555_5555_5556, 0, '0});
		tbl.push_back('{ACT_ADD,   48'h10, 0, '0});
		tbl.push_back('{ACT_NEAR,  48'h8, 0, '0});
		tbl.push_back('{ACT_CLEAR, mx,  1, w('0, 0, KIND_NONE, 0, 0)});
		tbl.push_back('{ACT_NEAR,  48'h1234, 1, w(mx - 7, 0, KIND_NEW, 1, 0)});
		foreach (tbl[i]) send_word(tbl[i].action, tbl[i].key, tbl[i].fixed, tbl[i].want);
		drain();

		// top of space, an unaligned base, a random base, then base 0
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_base(mx - 31);
				1: write_base(48'h0000_0000_0013);
				2: write_base(addr_t'({$urandom, $urandom}));
				default: write_base('0);
			endcase
			send_word(ACT_CLEAR, '0, 0, '0);
			b = addr_t'({$urandom, $urandom});
			if (ph == 1) begin
				// fill the map to overflow
				for (int i = 0; i < DEPTH + 6; i++)
					send_word(ACT_ADD, b + addr_t'(i) * 48'h200_0000, 0, '0);
				send_word(ACT_NEAR, b - 1, 0, '0);
				send_word(ACT_NEAR, b + 5, 0, '0);
			end else begin
				for (int i = 0; i < 60; i++) begin
					r = $urandom_range(0, 19);
					k = b + addr_t'($urandom_range(0, 63)) * 48'h80_0000
						+ addr_t'($urandom_range(0, 3) == 0 ? $urandom_range(0, 7) * 8 : 0);
					if (r == 0)
						send_word(2'($urandom_range(2, 3)), addr_t'({$urandom, $urandom}),
							0, '0);
					else if (r < 3)
						send_word(2'($urandom_range(0, 1)), addr_t'({$urandom, $urandom}),
							0, '0);
					else
						send_word(2'($urandom_range(0, 1)), k, 0, '0);
				end
			end
			drain();
		end

		$display("Sent %0d requests, checked %0d words: %0d near hits, %0d map-full refusals.",
			n_sent, n_got, n_near, n_full);
		$display("Covered reset defaults, clear and unused action, base extremes and wrap.");
		if (errors == 0 && pending_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
